[sv/srt_pkg.sv]
`timescale 1ns / 1ps

package srt_pkg;

    // Phase codes
    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_HOLD  = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_TICK_WRAP = 3'd0;
    localparam logic [2:0] CFG_FLASH_SEC = 3'd1;
    localparam logic [2:0] CFG_BLANK_TCK = 3'd2;
    localparam logic [2:0] CFG_MIN_SEC   = 3'd3;
    localparam logic [2:0] CFG_HOLD_MIN  = 3'd4;
    localparam logic [2:0] CFG_HOLD_MAX  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_TICK_WRAP = 8'd189;
    localparam logic [6:0] RST_FLASH_SEC = 7'd35;
    localparam logic [7:0] RST_BLANK_TCK = 8'd64;
    localparam logic [6:0] RST_MIN_SEC   = 7'd3;
    localparam logic [4:0] RST_HOLD_MIN  = 5'd5;
    localparam logic [4:0] RST_HOLD_MAX  = 5'd20;

    localparam logic [2:0] B_OFF       = 3'h7;
    localparam logic [5:0] C_OFF       = 6'h3f;
    localparam logic [5:0] ANODE_UNITS = 6'h08;
    localparam logic [5:0] ANODE_TENS  = 6'h10;
    localparam logic [6:0] SECONDS_MAX = 7'd99;
    localparam logic [4:0] HOLD_SAT    = 5'd31;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [7:0] tick_wrap;
        logic [6:0] flash_sec;
        logic [7:0] blank_tck;
        logic [6:0] min_sec;
        logic [4:0] hold_min;
        logic [4:0] hold_max;
    } t_cfg;

    typedef struct packed {
        logic [1:0] phase;
        logic [6:0] seconds;
        logic [5:0] port_c;
        logic [2:0] port_b;
    } t_result;

    typedef struct packed {
        logic [2:0] port_b;
        logic [5:0] port_c;
    } t_segs;

    function automatic logic [2:0] seg_b(input logic [3:0] digit);
        logic [2:0] v;
        unique case (digit)
            4'd0:    v = 3'h1;
            4'd1:    v = 3'h7;
            4'd2:    v = 3'h2;
            4'd3:    v = 3'h2;
            4'd4:    v = 3'h4;
            4'd5:    v = 3'h0;
            4'd6:    v = 3'h0;
            4'd7:    v = 3'h3;
            4'd8:    v = 3'h0;
            4'd9:    v = 3'h0;
            default: v = B_OFF;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] seg_c(input logic [3:0] digit);
        logic [5:0] v;
        unique case (digit)
            4'd0:    v = 6'h00;
            4'd1:    v = 6'h06;
            4'd2:    v = 6'h01;
            4'd3:    v = 6'h04;
            4'd4:    v = 6'h06;
            4'd5:    v = 6'h24;
            4'd6:    v = 6'h20;
            4'd7:    v = 6'h06;
            4'd8:    v = 6'h00;
            4'd9:    v = 6'h04;
            default: v = C_OFF;
        endcase
        return v;
    endfunction

endpackage

[sv/srt_cfg_regs.sv]
`timescale 1ns / 1ps

module srt_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [srt_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]  i_data,
    output srt_pkg::t_cfg                   o_cfg
);

    srt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_wrap <= srt_pkg::RST_TICK_WRAP;
            r_cfg.flash_sec <= srt_pkg::RST_FLASH_SEC;
            r_cfg.blank_tck <= srt_pkg::RST_BLANK_TCK;
            r_cfg.min_sec   <= srt_pkg::RST_MIN_SEC;
            r_cfg.hold_min  <= srt_pkg::RST_HOLD_MIN;
            r_cfg.hold_max  <= srt_pkg::RST_HOLD_MAX;
        end else if (i_we) begin
            unique case (i_index)
                srt_pkg::CFG_TICK_WRAP: r_cfg.tick_wrap <= i_data;
                srt_pkg::CFG_FLASH_SEC: r_cfg.flash_sec <= i_data[6:0];
                srt_pkg::CFG_BLANK_TCK: r_cfg.blank_tck <= i_data;
                srt_pkg::CFG_MIN_SEC:   r_cfg.min_sec   <= i_data[6:0];
                srt_pkg::CFG_HOLD_MIN:  r_cfg.hold_min  <= i_data[4:0];
                srt_pkg::CFG_HOLD_MAX:  r_cfg.hold_max  <= i_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/srt_seg_decode.sv]
`timescale 1ns / 1ps

module srt_seg_decode (
    input  logic [6:0]       i_seconds,
    input  logic [7:0]       i_tick,
    input  srt_pkg::t_cfg    i_cfg,
    output srt_pkg::t_segs   o_segs
);

    logic [3:0] tens_full;
    logic [3:0] tens_digit;
    logic [3:0] units_digit;
    logic [6:0] tens_x10;
    logic [6:0] units_wide;
    logic [3:0] digit;
    logic       show;

    // Quotient by ten through a threshold chain on the 7-bit count.
    always_comb begin
        if      (i_seconds >= 7'd120) tens_full = 4'd12;
        else if (i_seconds >= 7'd110) tens_full = 4'd11;
        else if (i_seconds >= 7'd100) tens_full = 4'd10;
        else if (i_seconds >= 7'd90)  tens_full = 4'd9;
        else if (i_seconds >= 7'd80)  tens_full = 4'd8;
        else if (i_seconds >= 7'd70)  tens_full = 4'd7;
        else if (i_seconds >= 7'd60)  tens_full = 4'd6;
        else if (i_seconds >= 7'd50)  tens_full = 4'd5;
        else if (i_seconds >= 7'd40)  tens_full = 4'd4;
        else if (i_seconds >= 7'd30)  tens_full = 4'd3;
        else if (i_seconds >= 7'd20)  tens_full = 4'd2;
        else if (i_seconds >= 7'd10)  tens_full = 4'd1;
        else                          tens_full = 4'd0;
    end

    assign tens_x10    = {tens_full, 3'b000} + {2'b00, tens_full, 1'b0};
    assign units_wide  = i_seconds - tens_x10;
    assign units_digit = units_wide[3:0];
    assign tens_digit  = (tens_full >= 4'd10) ? (tens_full - 4'd10) : tens_full;

    assign show  = (i_seconds < i_cfg.flash_sec) || (i_tick > i_cfg.blank_tck);
    assign digit = i_tick[0] ? units_digit : tens_digit;

    always_comb begin
        if (show) begin
            o_segs.port_b = srt_pkg::seg_b(digit);
            o_segs.port_c = srt_pkg::seg_c(digit) |
                            (i_tick[0] ? srt_pkg::ANODE_UNITS : srt_pkg::ANODE_TENS);
        end else begin
            o_segs.port_b = srt_pkg::B_OFF;
            o_segs.port_c = srt_pkg::C_OFF;
        end
    end

endmodule

[sv/srt_core.sv]
`timescale 1ns / 1ps

module srt_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_on,
    input  srt_pkg::t_cfg      i_cfg,
    output srt_pkg::t_result   o_next
);

    logic [7:0] r_tick,    n_tick;
    logic [6:0] r_seconds, n_seconds;
    logic [4:0] r_hold,    n_hold;
    logic [1:0] r_phase,   n_phase;
    logic [2:0] r_port_b,  n_port_b;
    logic [5:0] r_port_c,  n_port_c;

    logic [7:0]      tick_adv;
    logic [4:0]      hold_inc;
    srt_pkg::t_segs  segs;

    assign tick_adv = (r_tick >= i_cfg.tick_wrap) ? 8'd0 : (r_tick + 8'd1);

    srt_seg_decode u_seg (
        .i_seconds (r_seconds),
        .i_tick    (tick_adv),
        .i_cfg     (i_cfg),
        .o_segs    (segs)
    );

    assign hold_inc = ((tick_adv == 8'd0) && (r_hold < srt_pkg::HOLD_SAT)) ?
                      (r_hold + 5'd1) : r_hold;

    always_comb begin
        n_tick    = tick_adv;
        n_seconds = r_seconds;
        n_hold    = r_hold;
        n_phase   = r_phase;
        n_port_b  = r_port_b;
        n_port_c  = r_port_c;
        unique case (r_phase)
            srt_pkg::PH_COUNT: begin
                if (i_on) begin
                    if (r_seconds != 7'd0) begin
                        n_port_b = segs.port_b;
                        n_port_c = segs.port_c;
                    end
                    if ((tick_adv == 8'd0) && (r_seconds < srt_pkg::SECONDS_MAX)) begin
                        n_seconds = r_seconds + 7'd1;
                    end
                end else begin
                    n_hold = 5'd0;
                    // The display keeps its last digit when the hold starts.
                    if ((r_seconds > i_cfg.min_sec) && (i_cfg.hold_max != 5'd0)) begin
                        n_phase = srt_pkg::PH_HOLD;
                    end else begin
                        n_port_b = srt_pkg::B_OFF;
                        n_port_c = srt_pkg::C_OFF;
                        n_phase  = srt_pkg::PH_WAIT;
                    end
                end
            end
            srt_pkg::PH_HOLD: begin
                if (!i_on || (r_hold < i_cfg.hold_min)) begin
                    n_hold = hold_inc;
                    if (hold_inc >= i_cfg.hold_max) begin
                        n_port_b = srt_pkg::B_OFF;
                        n_port_c = srt_pkg::C_OFF;
                        n_phase  = srt_pkg::PH_WAIT;
                    end else begin
                        n_port_b = segs.port_b;
                        n_port_c = segs.port_c;
                    end
                end else begin
                    n_port_b = srt_pkg::B_OFF;
                    n_port_c = srt_pkg::C_OFF;
                    n_phase  = srt_pkg::PH_WAIT;
                end
            end
            default: begin
                // Waiting; the unused code behaves the same way.
                n_phase = srt_pkg::PH_WAIT;
                if (i_on) begin
                    n_tick    = 8'd0;
                    n_seconds = 7'd0;
                    n_phase   = srt_pkg::PH_COUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= 8'd0;
            r_seconds <= 7'd0;
            r_hold    <= 5'd0;
            r_phase   <= srt_pkg::PH_COUNT;
            r_port_b  <= srt_pkg::B_OFF;
            r_port_c  <= srt_pkg::C_OFF;
        end else if (i_fire) begin
            r_tick    <= n_tick;
            r_seconds <= n_seconds;
            r_hold    <= n_hold;
            r_phase   <= n_phase;
            r_port_b  <= n_port_b;
            r_port_c  <= n_port_c;
        end
    end

    assign o_next.phase   = n_phase;
    assign o_next.seconds = n_seconds;
    assign o_next.port_c  = n_port_c;
    assign o_next.port_b  = n_port_b;

endmodule

[sv/solenoid_run_timer_with_led_display_top.sv]
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tick samples, one word per tick
// m_axis    | out       | m_axis_tvalid / m_axis_tready | port drive, seconds, phase
// cfg       | in        | i_cfg_valid / o_cfg_ready     | register index and data
//
// One word is accepted per cycle while the output is not stalled; its result word
// passes through the input register, then the state update into the result register.
// The phase and seconds state is a single register set updated once per word.
// Reset is synchronous and active low; configuration writes are always ready.
// A stall holds the result and any full input word; input ready follows output space.

module solenoid_run_timer_with_led_display_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] sample_first, [1] sample_second, [7:2] zero
    input  logic [srt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] port_b, [8:3] port_c, [15:9] seconds_shown, [17:16] phase, [23:18] zero
    output logic [srt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [srt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    srt_pkg::t_cfg    cfg;
    srt_pkg::t_result next_res;

    logic             r_in_valid;
    logic             r_in_on;
    logic             r_out_valid;
    srt_pkg::t_result r_out;

    logic             advance;
    logic             fire;

    assign o_cfg_ready = 1'b1;

    srt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The pipeline moves whenever the result register is free or being taken.
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_on <= s_axis_tdata[0] & s_axis_tdata[1];
        end
    end

    srt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_on    (r_in_on),
        .i_cfg   (cfg),
        .o_next  (next_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= next_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule

[sv/srt_checker.sv]
`timescale 1ns / 1ps

module srt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [srt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // Once waiting, the display must be dark.
    a_wait_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[17:16] == srt_pkg::PH_WAIT))
        |-> ((m_axis_tdata[2:0] == srt_pkg::B_OFF) && (m_axis_tdata[8:3] == srt_pkg::C_OFF)))
        else $error("display not blank while waiting");

    a_seconds_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:9] <= srt_pkg::SECONDS_MAX))
        else $error("seconds count past saturation");

    // At most one digit anode may be driven at a time.
    a_one_anode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:6] != 2'b00))
        else $error("both digit anodes driven");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind solenoid_run_timer_with_led_display_top srt_checker u_srt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import srt_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    // Indexes past the last register; writes there must change nothing.
    localparam logic [2:0] CFG_UNUSED_A = 3'd6;
    localparam logic [2:0] CFG_UNUSED_B = 3'd7;

    typedef struct packed {
        logic second;
        logic first;
    } t_sample_pair;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    solenoid_run_timer_with_led_display_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Segment patterns per digit, active low.
    logic [2:0] seg_b_lut [0:9] = '{3'h1, 3'h7, 3'h2, 3'h2, 3'h4, 3'h0, 3'h0, 3'h3, 3'h0, 3'h0};
    logic [5:0] seg_c_lut [0:9] = '{6'h00, 6'h06, 6'h01, 6'h04, 6'h06, 6'h24, 6'h20, 6'h06,
                                    6'h00, 6'h04};

    // Timer state as the block should hold it.
    t_cfg       tm_cfg = '{RST_TICK_WRAP, RST_FLASH_SEC, RST_BLANK_TCK, RST_MIN_SEC,
                           RST_HOLD_MIN, RST_HOLD_MAX};
    logic [7:0] tm_tick  = '0;
    logic [6:0] tm_secs  = '0;
    logic [4:0] tm_hold  = '0;
    logic [1:0] tm_phase = PH_COUNT;
    logic [2:0] tm_pb    = B_OFF;
    logic [5:0] tm_pc    = C_OFF;

    t_sample_pair sample_q [$];
    t_result      display_q [$];

    bit in_fire, out_fire, cfg_fire;
    int in_gap, out_stall, max_gap, max_stall;
    int n_queued, n_taken, n_checked, n_errors, n_settings, n_holds, max_secs, idle_cycles;

    function automatic t_segs digit_drive(input logic [6:0] secs, input logic [7:0] tick);
        t_segs      d;
        logic [3:0] digit;
        d.port_b = B_OFF;
        d.port_c = C_OFF;
        if (secs < tm_cfg.flash_sec || tick > tm_cfg.blank_tck) begin
            if (tick[0]) begin
                digit = 4'(secs % 10);
                d.port_c = seg_c_lut[digit] | ANODE_UNITS;
            end else begin
                digit = 4'((secs / 10) % 10);
                d.port_c = seg_c_lut[digit] | ANODE_TENS;
            end
            d.port_b = seg_b_lut[digit];
        end
        return d;
    endfunction

    task automatic advance_timer(input logic first, input logic second, output t_result r);
        logic  on;
        t_segs d;
        on = first & second;
        if (tm_tick >= tm_cfg.tick_wrap) tm_tick = '0;
        else tm_tick = tm_tick + 8'd1;
        case (tm_phase)
            PH_COUNT: begin
                if (on) begin
                    if (tm_secs > 0) begin
                        d = digit_drive(tm_secs, tm_tick);
                        {tm_pb, tm_pc} = {d.port_b, d.port_c};
                    end
                    if (tm_tick == 0 && tm_secs < SECONDS_MAX) tm_secs = tm_secs + 7'd1;
                end else begin
                    tm_hold = '0;
                    if (tm_secs > tm_cfg.min_sec && tm_cfg.hold_max > 0) begin
                        tm_phase = PH_HOLD;
                        n_holds++;
                    end else begin
                        {tm_pb, tm_pc} = {B_OFF, C_OFF};
                        tm_phase = PH_WAIT;
                    end
                end
            end
            PH_HOLD: begin
                if (!on || tm_hold < tm_cfg.hold_min) begin
                    d = digit_drive(tm_secs, tm_tick);
                    {tm_pb, tm_pc} = {d.port_b, d.port_c};
                    if (tm_tick == 0 && tm_hold < HOLD_SAT) tm_hold = tm_hold + 5'd1;
                    if (tm_hold >= tm_cfg.hold_max) begin
                        {tm_pb, tm_pc} = {B_OFF, C_OFF};
                        tm_phase = PH_WAIT;
                    end
                end else begin
                    {tm_pb, tm_pc} = {B_OFF, C_OFF};
                    tm_phase = PH_WAIT;
                end
            end
            default: begin
                tm_phase = PH_WAIT;
                if (on) begin
                    tm_tick  = '0;
                    tm_secs  = '0;
                    tm_phase = PH_COUNT;
                end
            end
        endcase
        if (tm_secs > max_secs) max_secs = tm_secs;
        r.port_b  = tm_pb;
        r.port_c  = tm_pc;
        r.seconds = tm_secs;
        r.phase   = tm_phase;
    endtask

    // Input driver: one tick word at a time, random gaps between words.
    always @(negedge i_clk) begin
        logic                 nxt_valid;
        logic [IN_DATA_W-1:0] nxt_data;
        t_sample_pair         p;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (!s_axis_tvalid || in_fire) begin
            nxt_valid = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (sample_q.size() > 0) begin
                p = sample_q.pop_front();
                nxt_valid = 1'b1;
                nxt_data  = {6'b0, p.second, p.first};
                in_gap    = $urandom_range(0, max_gap);
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // Output back-pressure: a random stall after each accepted result word.
    always @(negedge i_clk) begin
        if (out_fire) out_stall = $urandom_range(0, max_stall);
        if (out_stall > 0) begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            in_fire  = 1'b0;
            out_fire = 1'b0;
            cfg_fire = 1'b0;
        end else begin
            in_fire  = s_axis_tvalid && s_axis_tready;
            out_fire = m_axis_tvalid && m_axis_tready;
            cfg_fire = i_cfg_valid && o_cfg_ready;
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_TICK_WRAP: tm_cfg.tick_wrap = i_cfg_data;
                    CFG_FLASH_SEC: tm_cfg.flash_sec = i_cfg_data[6:0];
                    CFG_BLANK_TCK: tm_cfg.blank_tck = i_cfg_data;
                    CFG_MIN_SEC:   tm_cfg.min_sec   = i_cfg_data[6:0];
                    CFG_HOLD_MIN:  tm_cfg.hold_min  = i_cfg_data[4:0];
                    CFG_HOLD_MAX:  tm_cfg.hold_max  = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                advance_timer(s_axis_tdata[0], s_axis_tdata[1], want);
                display_q.push_back(want);
                n_taken++;
            end
            if (out_fire) begin
                got = m_axis_tdata[17:0];
                if (display_q.size() == 0) begin
                    $error("result word 0x%06h with no tick pending", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = display_q.pop_front();
                    if (got.port_b !== want.port_b) begin
                        $error("port_b: expected %0d, got %0d", want.port_b, got.port_b);
                        n_errors++;
                    end
                    if (got.port_c !== want.port_c) begin
                        $error("port_c: expected %0d, got %0d", want.port_c, got.port_c);
                        n_errors++;
                    end
                    if (got.seconds !== want.seconds) begin
                        $error("seconds_shown: expected %0d, got %0d", want.seconds,
                               got.seconds);
                        n_errors++;
                    end
                    if (got.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, got.phase);
                        n_errors++;
                    end
                    if (m_axis_tdata[23:18] !== '0) begin
                        $error("padding: expected 0, got %0d", m_axis_tdata[23:18]);
                        n_errors++;
                    end
                end
                n_checked++;
            end
            if (in_fire || out_fire || cfg_fire) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    // With junk set, the unused upper data bits of the narrow registers are random.
    task automatic apply_settings(input int wrap, input int flash, input int blank,
                                  input int min_s, input int h_min, input int h_max,
                                  input bit junk);
        logic [7:0] hi;
        hi = junk ? 8'($urandom_range(0, 255)) : 8'h00;
        write_reg(CFG_TICK_WRAP, 8'(wrap));
        write_reg(CFG_FLASH_SEC, {hi[7], 7'(flash)});
        write_reg(CFG_BLANK_TCK, 8'(blank));
        write_reg(CFG_MIN_SEC,   {hi[6], 7'(min_s)});
        write_reg(CFG_HOLD_MIN,  {hi[5:3], 5'(h_min)});
        write_reg(CFG_HOLD_MAX,  {hi[2:0], 5'(h_max)});
        n_settings++;
        @(posedge i_clk);
        max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 12;
        max_stall = ($urandom_range(0, 2) == 0) ? 0 : 12;
    endtask

    task automatic push_ticks(input t_sample_pair p, input int count);
        repeat (count) sample_q.push_back(p);
        n_queued += count;
    endtask

    // Press and release sessions; about one word in ten is a random sample pair.
    task automatic queue_sessions(input int n, input int tps, input int hold_span);
        int           added;
        int           len;
        int           k;
        int           cap;
        t_sample_pair p;
        added = 0;
        while (added < n) begin
            cap = (tps * 8 < 60) ? tps * 8 : 60;
            len = $urandom_range(1, cap);
            for (k = 0; k < len; k++) begin
                p = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'b11;
                sample_q.push_back(p);
            end
            added += len;
            cap = (tps * (hold_span + 3) < 60) ? tps * (hold_span + 3) : 60;
            len = $urandom_range(1, cap);
            for (k = 0; k < len; k++) begin
                p = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'b00;
                sample_q.push_back(p);
            end
            added += len;
        end
        n_queued += added;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (n_taken != n_queued || display_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int wrap;
        int flash;
        int blank;
        int min_s;
        int h_min;
        int h_max;
        max_gap   = 12;
        max_stall = 12;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: release with nothing counted, stray single samples while waiting.
        push_ticks(2'b00, 1);
        push_ticks(2'b01, 1);
        push_ticks(2'b10, 1);
        push_ticks(2'b00, 1);
        push_ticks(2'b11, 3);
        push_ticks(2'b10, 1);
        push_ticks(2'b11, 1);
        wait_drained();

        // Smallest settings: count a few seconds, hold one second, then leave hold
        // at once when the solenoid comes back with a zero hold minimum.
        apply_settings(1, 0, 0, 0, 0, 1, 1'b0);
        push_ticks(2'b11, 6);
        push_ticks(2'b00, 3);
        push_ticks(2'b11, 4);
        push_ticks(2'b00, 1);
        push_ticks(2'b11, 1);
        push_ticks(2'b00, 1);
        wait_drained();

        apply_settings(255, 99, 255, 99, 31, 31, 1'b0);
        write_reg(CFG_UNUSED_A, 8'hff);
        write_reg(CFG_UNUSED_B, 8'h00);
        @(posedge i_clk);
        queue_sessions(40, 256, 31);
        wait_drained();

        // Every tick is a second: run the count into saturation, past the flash limit.
        apply_settings(0, 60, 0, 2, 1, 3, 1'b1);
        push_ticks(2'b11, 110);
        queue_sessions(20, 1, 3);
        wait_drained();

        // A zero hold maximum never enters the hold phase.
        apply_settings(2, 3, 1, 1, 0, 0, 1'b1);
        queue_sessions(40, 3, 2);
        wait_drained();

        repeat (3) begin
            wrap  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
            flash = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 12);
            blank = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, (wrap < 254) ? wrap + 1 : 255);
            min_s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 4);
            h_min = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
            h_max = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 10);
            apply_settings(wrap, flash, blank, min_s, h_min, h_max, 1'b1);
            queue_sessions(40, wrap + 1, h_max);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        $display("Checked %0d result words across %0d register settings.", n_checked,
                 n_settings);
        $display("Counting reached %0d s at most; the hold phase was entered %0d times.",
                 max_secs, n_holds);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
sv/srt_pkg.sv
sv/srt_cfg_regs.sv
sv/srt_seg_decode.sv
sv/srt_core.sv
sv/solenoid_run_timer_with_led_display_top.sv
sv/srt_checker.sv
tb/sv/tb.sv
